[sv/f32h_pkg.sv]
// ----------------------------------------------------------------------------
// Format converter package
// Shared commands, widths and constants for the single/half converter.
// ----------------------------------------------------------------------------
`default_nettype none

package f32h_pkg;

    localparam int unsigned WordWidth = 32;

    typedef enum logic
    {
        CMD_TO_HALF   = 1'b0,
        CMD_TO_SINGLE = 1'b1
    } command_t;

    localparam logic [31:0] SGL_INF_BITS = 32'h7F80_0000;
    localparam logic [31:0] HLF_CLAMP    = 32'h0F80_0000;
    localparam logic [31:0] LOW_CLEAR    = 32'hFFFF_F000;
    localparam logic [15:0] HLF_NAN      = 16'h7E00;
    localparam logic [15:0] HLF_INF      = 16'h7C00;

endpackage

`default_nettype wire

[sv/fp32_fp16_format_converter.sv]
// ----------------------------------------------------------------------------
// Single/half precision format converter
// Converts one IEEE value per transfer between single and half precision.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) carries a command, the operand
// and an end-of-block flag. Command CMD_TO_HALF turns single bits into half
// bits in the low 16 bits of the result; CMD_TO_SINGLE widens the low 16 bits
// of the operand into single bits exactly. The output channel
// (out_valid/out_stall) carries the result and the flag copy.
// Path: an accepted item waits in the input register and then moves to the
// result register, which drives the output; an output stall holds it in the
// input register until the result register can take it.
// Throughput: one item every cycle while the output is not stalled; the
// conversion logic between the input and result registers is a single pass.
// Reset clears both valid bits; no item is in flight afterward.
// When the receiver stalls, the result holds and the input register fills;
// the input side stalls only when both registers hold items.
// ----------------------------------------------------------------------------
`default_nettype none

module fp32_fp16_format_converter
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           command,
    input  wire logic [f32h_pkg::WordWidth-1:0] operand_bits,
    input  wire logic                           end_of_block,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [f32h_pkg::WordWidth-1:0] converted_bits,
    output logic                                end_of_block_out
);
    import f32h_pkg::*;

    logic        in_vld_reg;
    logic        cmd_reg;
    logic [31:0] op_reg;
    logic        eob_reg;
    logic        out_vld_reg;
    logic [31:0] res_reg;
    logic        res_eob_reg;
    logic        advance;
    logic [31:0] res_next;

    // The input register moves on whenever the result register can take it.
    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;

    // Single to half path.
    logic [31:0] sign_bit;
    logic [31:0] mag;
    logic [31:0] cleared;
    logic [7:0]  exp_s;
    logic [23:0] sig;
    logic [7:0]  shamt;
    logic [31:0] scaled;
    logic [23:0] quo;
    logic [23:0] rem;
    logic [23:0] halfway;
    logic [31:0] biased;
    logic [15:0] half_res;

    always_comb
    begin
        sign_bit = op_reg & 32'h8000_0000;
        mag      = op_reg ^ sign_bit;
        cleared  = mag & LOW_CLEAR;
        exp_s    = cleared[30:23];
        sig      = (exp_s == 8'd0) ? {1'b0, cleared[22:0]} : {1'b1, cleared[22:0]};
        shamt    = (exp_s == 8'd0) ? 8'd112 : 8'd113 - exp_s;
        quo      = '0;
        rem      = '0;
        halfway  = '0;
        scaled   = '0;
        if (exp_s >= 8'd113)
        begin
            scaled = cleared - (32'd112 << 23);
        end
        else if (shamt <= 8'd31)
        begin
            // Shift by at most 24 matters; larger shifts leave all bits in the rest.
            if (shamt >= 8'd25)
            begin
                quo     = '0;
                rem     = sig;
                halfway = '0;
                scaled  = 32'd0;
            end
            else
            begin
                quo     = sig >> shamt[4:0];
                rem     = sig & ((24'd1 << shamt[4:0]) - 24'd1);
                halfway = 24'd1 << (shamt[4:0] - 5'd1);
                scaled  = {8'd0, quo};
                if (rem > halfway || (rem == halfway && quo[0]))
                begin
                    scaled = scaled + 32'd1;
                end
            end
        end
        biased = scaled + 32'h0000_1000;
        if (biased > HLF_CLAMP)
        begin
            biased = HLF_CLAMP;
        end
        if (mag > SGL_INF_BITS)
        begin
            half_res = HLF_NAN;
        end
        else if (mag == SGL_INF_BITS)
        begin
            half_res = HLF_INF;
        end
        else
        begin
            half_res = biased[28:13];
        end
        half_res = half_res | sign_bit[31:16];
    end

    // Half to single path.
    logic [4:0]  exp_h;
    logic [9:0]  man_h;
    logic [3:0]  lead;
    logic [31:0] single_res;

    always_comb
    begin
        exp_h = op_reg[14:10];
        man_h = op_reg[9:0];
        lead  = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (man_h[i])
            begin
                lead = 4'(i);
            end
        end
        if (exp_h == 5'd31)
        begin
            single_res = SGL_INF_BITS | {9'd0, man_h, 13'd0};
        end
        else if (exp_h == 5'd0)
        begin
            if (man_h == 10'd0)
            begin
                single_res = 32'd0;
            end
            else
            begin
                single_res = {1'b0, 8'(8'd103 + {4'd0, lead}),
                              23'({man_h, 13'd0} << (4'd10 - lead))};
            end
        end
        else
        begin
            single_res = {1'b0, 8'({3'd0, exp_h} + 8'd112), man_h, 13'd0};
        end
        single_res = single_res | {op_reg[15], 31'd0};
    end

    // Select the result for the current command.
    always_comb
    begin
        unique case (command_t'(cmd_reg))
            CMD_TO_SINGLE: res_next = single_res;
            CMD_TO_HALF:   res_next = {16'd0, half_res};
            default:       res_next = {16'd0, half_res};
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            cmd_reg <= command;
            op_reg  <= operand_bits;
            eob_reg <= end_of_block;
        end
        if (advance && in_vld_reg)
        begin
            res_reg     <= res_next;
            res_eob_reg <= eob_reg;
        end
    end

    assign out_valid        = out_vld_reg;
    assign converted_bits   = res_reg;
    assign end_of_block_out = res_eob_reg;

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Format converter testbench
// Drives single/half conversions with random idling and stalls and compares
// every result transfer with an independent prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import f32h_pkg::*;

    typedef struct packed
    {
        logic [31:0] bits;
        logic        eob;
    } conv_result_t;

    localparam int ResultDepth = 1024;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [31:0] operand_bits;
    logic        end_of_block;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] converted_bits;
    logic        end_of_block_out;

    conv_result_t expected_results[ResultDepth];
    int          wr_count;
    int          rd_count;
    int          error_count;
    int          cycle_count;
    int          sent_count;
    int          checked_count;
    int          idle_percent;
    int          stall_percent;

    fp32_fp16_format_converter i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .operand_bits     (operand_bits),
        .end_of_block     (end_of_block),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .converted_bits   (converted_bits),
        .end_of_block_out (end_of_block_out)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Scale a magnitude below infinity by 2^-112, rounding to nearest even.
    function automatic logic [31:0] scale_by_pow2_m112(input logic [31:0] mag);
        logic [31:0] expo;
        logic [31:0] sig;
        int          shift;
        logic [63:0] quot;
        logic [63:0] rem;
        logic [63:0] halfway;
        expo = {24'd0, mag[30:23]};
        if (expo >= 113)
            return mag - (32'd112 << 23);
        if (expo == 0)
        begin
            sig = {9'd0, mag[22:0]};
            shift = 112;
        end
        else
        begin
            sig = {9'd1, mag[22:0]};
            shift = 113 - expo;
        end
        if (shift > 31)
            return 32'd0;
        quot = {32'd0, sig} >> shift;
        rem = {32'd0, sig} & ((64'd1 << shift) - 64'd1);
        halfway = 64'd1 << (shift - 1);
        if (rem > halfway || (rem == halfway && quot[0]))
            quot = quot + 64'd1;
        return quot[31:0];
    endfunction

    // Single bits to half bits, with the block's shortcut rounding.
    function automatic logic [31:0] narrow_to_half(input logic [31:0] x);
        logic [31:0] mag;
        logic [31:0] u;
        logic [15:0] h;
        mag = {1'b0, x[30:0]};
        if (mag >= SGL_INF_BITS)
            h = (mag > SGL_INF_BITS) ? HLF_NAN : HLF_INF;
        else
        begin
            u = scale_by_pow2_m112(mag & LOW_CLEAR) + 32'h1000;
            if (u > HLF_CLAMP)
                u = HLF_CLAMP;
            h = u[28:13];
        end
        h[15] = x[31];
        return {16'd0, h};
    endfunction

    // Half bits to single bits, exact.
    function automatic logic [31:0] widen_to_single(input logic [31:0] x);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [31:0] bits;
        int          p;
        e = x[14:10];
        m = x[9:0];
        if (e == 5'd31)
            bits = SGL_INF_BITS | ({22'd0, m} << 13);
        else if (e == 5'd0)
        begin
            if (m == 0)
                bits = 32'd0;
            else
            begin
                p = 9;
                while (!m[p])
                    p--;
                bits = 32'((p + 103) << 23) | (({22'd0, m} << (23 - p)) & 32'h7F_FFFF);
            end
        end
        else
            bits = ({27'd0, e} + 32'd112) << 23 | ({22'd0, m} << 13);
        bits[31] = x[15];
        return bits;
    endfunction

    // Send one item and record its predicted result once it is accepted.
    // The valid line stays high after the transfer; the next call or the
    // drain task decides what it does next.
    task automatic send_conversion(input command_t cmd, input logic [31:0] op,
                                   input logic eob);
        conv_result_t pred;
        while (($urandom_range(99) < idle_percent))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        operand_bits <= op;
        end_of_block <= eob;
        pred.bits = (cmd == CMD_TO_SINGLE) ? widen_to_single(op) : narrow_to_half(op);
        pred.eob  = eob;
        do
            @(posedge clk);
        while (in_stall);
        expected_results[wr_count % ResultDepth] = pred;
        wr_count++;
        sent_count++;
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (rd_count != wr_count)
            @(posedge clk);
    endtask

    // Field extremes, specials on both paths and rounding boundaries.
    task automatic test_directed();
        logic [31:0] cases[$];
        cases = {32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0001, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h477F_E000,
                 32'h4780_0000, 32'h3380_0000, 32'h3300_0000, 32'h3380_1000,
                 32'h0000_0001, 32'h387F_F000, 32'h3F80_0000};
        foreach (cases[i])
            send_conversion(CMD_TO_HALF, cases[i], i[0]);
        cases = {32'h0000_0000, 32'hFFFF_8000, 32'h0000_7C00, 32'h1234_FC00,
                 32'h0000_7E01, 32'h0000_0001, 32'h0000_03FF, 32'h0000_7BFF,
                 32'hABCD_3C00, 32'h0000_8200};
        foreach (cases[i])
            send_conversion(CMD_TO_SINGLE, cases[i], i[0]);
    endtask

    // Random operands, biased toward exponents near the half range.
    task automatic test_random(input int count);
        logic [31:0] op;
        for (int i = 0; i < count; i++)
        begin
            op = $urandom();
            if ($urandom_range(3) != 0)
                op[30:23] = 8'($urandom_range(95, 146));
            send_conversion(command_t'($urandom_range(1)), op, 1'($urandom_range(1)));
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_full_rate();
        idle_percent  = 0;
        stall_percent = 0;
        test_random(120);
        idle_percent  = 29;
        stall_percent = 29;
    endtask

    // Result checker and receiver stalls.
    always @(posedge clk)
    begin
        conv_result_t exp_res;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && !out_stall)
            begin
                checked_count <= checked_count + 1;
                if (rd_count == wr_count)
                begin
                    $error("unexpected result transfer: %h", converted_bits);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_results[rd_count % ResultDepth];
                    rd_count++;
                    if (converted_bits !== exp_res.bits)
                    begin
                        $error("converted_bits: expected %h actual %h",
                               exp_res.bits, converted_bits);
                        error_count++;
                    end
                    if (end_of_block_out !== exp_res.eob)
                    begin
                        $error("end_of_block_out: expected %b actual %b",
                               exp_res.eob, end_of_block_out);
                        error_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_percent);
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        if (cycle_count > 200000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = 1'b0;
        operand_bits  = '0;
        end_of_block  = 1'b0;
        out_stall     = 1'b0;
        wr_count      = 0;
        rd_count      = 0;
        error_count   = 0;
        cycle_count   = 0;
        sent_count    = 0;
        checked_count = 0;
        idle_percent  = 29;
        stall_percent = 29;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_for_drain();
        test_random(180);
        test_full_rate();
        test_random(180);
        wait_for_drain();
        repeat (10) @(posedge clk);
        $display("Covered %0d transfers in both directions, %0d results checked,",
                 sent_count, checked_count);
        $display("with specials, rounding edges, stalls and a full-rate stretch.");
        if (error_count == 0 && rd_count == wr_count)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
